### rtl/core/gcb_pkg.sv
package gcb_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int PIXEL_BITS = 16;

   localparam int COL_BITS     = $clog2(MAX_WIDTH);
   localparam int DIM_BITS     = 11;
   localparam int PROD_BITS    = 2 * DIM_BITS;
   localparam int NODE_BITS    = 21;
   localparam int GRAY_BITS    = 16;
   localparam int CFG_BITS     = 16;
   localparam int CSR_IDX_BITS = 2;
   localparam int NUM_KINDS    = 6;
   localparam int KIND_BITS    = 3;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_MAX_GRAY     = 2'd2
   } csr_index_type;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_SOURCE = 3'd0,
      KIND_SINK   = 3'd1,
      KIND_LEFT   = 3'd2,
      KIND_RIGHT  = 3'd3,
      KIND_BELOW  = 3'd4,
      KIND_ABOVE  = 3'd5
   } kind_type;

   typedef struct packed {
      logic                 mode;
      logic [GRAY_BITS-1:0] pixel_value;
   } req_type;

   typedef struct packed {
      kind_type             edge_kind;
      logic [NODE_BITS-1:0] from_node;
      logic [NODE_BITS-1:0] to_node;
      logic [GRAY_BITS-1:0] capacity;
      logic [GRAY_BITS-1:0] edge_value;
      logic                 last;
   } rsp_type;

   // clamped image geometry and gray maximum
   typedef struct packed {
      logic [DIM_BITS-1:0]  width;
      logic [DIM_BITS-1:0]  height;
      logic [GRAY_BITS-1:0] max_gray;
   } cfg_type;

   // request state carried into the read/modify stage
   typedef struct packed {
      logic [COL_BITS-1:0]  x;
      logic [GRAY_BITS-1:0] v;
      logic                 emit;
      logic                 wprev;
      logic                 has_below;
      logic                 y_pos;
      logic [NODE_BITS-1:0] rowbase;
      logic [NODE_BITS-1:0] src;
   } stage_type;

   typedef struct packed {
      logic [GRAY_BITS-1:0] prev_cur;
      logic [GRAY_BITS-1:0] prev_right;
      logic [GRAY_BITS-1:0] rbp_left;
      logic [GRAY_BITS-1:0] rbp_cur;
   } mem_rd_type;

   typedef struct packed {
      logic [NUM_KINDS-1:0]                 mask;
      logic [NODE_BITS-1:0]                 me;
      logic [NODE_BITS-1:0]                 src;
      logic [GRAY_BITS-1:0]                 c;
      logic [GRAY_BITS-1:0]                 m;
      logic [NUM_KINDS-1:0][NODE_BITS-1:0]  to;
      logic [NUM_KINDS-1:0][GRAY_BITS-1:0]  cap;
   } edge_set_type;

   function automatic logic [GRAY_BITS-1:0] sat(input logic [GRAY_BITS-1:0] v,
                                                input logic [GRAY_BITS-1:0] m);
      return (v > m) ? m : v;
   endfunction

   function automatic logic [GRAY_BITS-1:0] weight(input logic [GRAY_BITS-1:0] m,
                                                   input logic [GRAY_BITS-1:0] a,
                                                   input logic [GRAY_BITS-1:0] b);
      logic [GRAY_BITS-1:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return (d > m) ? '0 : (m - d);
   endfunction

endpackage

### rtl/core/gcb_row_mem.sv
module gcb_row_mem
   import gcb_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  logic [COL_BITS-1:0]  rd_x,
   input  logic                 wr_prev,
   input  logic                 wr_rbp,
   input  logic [GRAY_BITS-1:0] wr_data,
   output mem_rd_type           rd_data
);

   logic [GRAY_BITS-1:0] prev_mem [MAX_WIDTH];
   logic [GRAY_BITS-1:0] rbp_mem  [MAX_WIDTH];

   logic [COL_BITS-1:0]  x_right;
   logic [COL_BITS-1:0]  x_left;
   logic [COL_BITS-1:0]  x_ff;
   logic [COL_BITS-1:0]  x_right_ff;
   logic [COL_BITS-1:0]  x_left_ff;
   logic [GRAY_BITS-1:0] prev_cur_ff;
   logic [GRAY_BITS-1:0] prev_right_ff;
   logic [GRAY_BITS-1:0] rbp_left_ff;
   logic [GRAY_BITS-1:0] rbp_cur_ff;

   // last write to each buffer, for a read issued in the same cycle
   logic                 pw_valid_ff;
   logic [COL_BITS-1:0]  pw_addr_ff;
   logic [GRAY_BITS-1:0] pw_data_ff;
   logic                 rw_valid_ff;
   logic [COL_BITS-1:0]  rw_addr_ff;
   logic [GRAY_BITS-1:0] rw_data_ff;

   assign x_right = rd_x + COL_BITS'(1);
   assign x_left  = rd_x - COL_BITS'(1);

   always_ff @(posedge clock) begin
      if (rd_en) begin
         x_ff          <= rd_x;
         x_right_ff    <= x_right;
         x_left_ff     <= x_left;
         prev_cur_ff   <= prev_mem[rd_x];
         prev_right_ff <= prev_mem[x_right];
         rbp_left_ff   <= rbp_mem[x_left];
         rbp_cur_ff    <= rbp_mem[rd_x];
      end
      if (wr_prev) begin
         prev_mem[x_ff] <= wr_data;
      end
      if (wr_rbp) begin
         rbp_mem[x_ff] <= rd_data.prev_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pw_valid_ff <= 1'b0;
         rw_valid_ff <= 1'b0;
      end else begin
         if (wr_prev) begin
            pw_valid_ff <= 1'b1;
         end
         if (wr_rbp) begin
            rw_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_prev) begin
         pw_addr_ff <= x_ff;
         pw_data_ff <= wr_data;
      end
      if (wr_rbp) begin
         rw_addr_ff <= x_ff;
         rw_data_ff <= rd_data.prev_cur;
      end
   end

   always_comb begin
      rd_data.prev_cur   = (pw_valid_ff && pw_addr_ff == x_ff) ? pw_data_ff : prev_cur_ff;
      rd_data.prev_right = (pw_valid_ff && pw_addr_ff == x_right_ff) ? pw_data_ff
                                                                     : prev_right_ff;
      rd_data.rbp_left   = (rw_valid_ff && rw_addr_ff == x_left_ff) ? rw_data_ff
                                                                    : rbp_left_ff;
      rd_data.rbp_cur    = (rw_valid_ff && rw_addr_ff == x_ff) ? rw_data_ff : rbp_cur_ff;
   end

endmodule

### rtl/core/gcb_edge_calc.sv
module gcb_edge_calc
   import gcb_pkg::*;
(
   input  stage_type    stage,
   input  mem_rd_type   rd_data,
   input  cfg_type      cfg,
   output edge_set_type edge_set
);

   logic [GRAY_BITS-1:0] m;
   logic [GRAY_BITS-1:0] c;
   logic [GRAY_BITS-1:0] lo;
   logic [GRAY_BITS-1:0] hi;
   logic [NODE_BITS-1:0] me;
   logic [NODE_BITS-1:0] w_node;
   logic [DIM_BITS-1:0]  x_next;

   always_comb begin
      m      = cfg.max_gray;
      c      = sat(rd_data.prev_cur, m);
      lo     = m >> 2;
      hi     = {lo[GRAY_BITS-2:0], 1'b0} + lo;
      me     = stage.rowbase + NODE_BITS'(stage.x);
      w_node = NODE_BITS'(cfg.width);
      x_next = DIM_BITS'(stage.x) + DIM_BITS'(1);

      edge_set.mask[KIND_SOURCE] = stage.emit && (c <= lo);
      edge_set.mask[KIND_SINK]   = stage.emit && (c >= hi);
      edge_set.mask[KIND_LEFT]   = stage.emit && (stage.x != '0);
      edge_set.mask[KIND_RIGHT]  = stage.emit && (x_next < cfg.width);
      edge_set.mask[KIND_BELOW]  = stage.emit && stage.has_below;
      edge_set.mask[KIND_ABOVE]  = stage.emit && stage.y_pos;

      edge_set.me  = me;
      edge_set.src = stage.src;
      edge_set.c   = c;
      edge_set.m   = m;

      edge_set.to[KIND_SOURCE] = me;
      edge_set.to[KIND_SINK]   = stage.src + NODE_BITS'(1);
      edge_set.to[KIND_LEFT]   = me - NODE_BITS'(1);
      edge_set.to[KIND_RIGHT]  = me + NODE_BITS'(1);
      edge_set.to[KIND_BELOW]  = me + w_node;
      edge_set.to[KIND_ABOVE]  = me - w_node;

      edge_set.cap[KIND_SOURCE] = '0;
      edge_set.cap[KIND_SINK]   = '0;
      edge_set.cap[KIND_LEFT]   = weight(m, c, sat(rd_data.rbp_left, m));
      edge_set.cap[KIND_RIGHT]  = weight(m, c, sat(rd_data.prev_right, m));
      edge_set.cap[KIND_BELOW]  = weight(m, c, stage.v);
      edge_set.cap[KIND_ABOVE]  = weight(m, c, sat(rd_data.rbp_cur, m));
   end

endmodule

### rtl/core/gcb_edge_seq.sv
module gcb_edge_seq
   import gcb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         set_valid,
   input  edge_set_type set_data,
   output logic         set_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data
);

   edge_set_type         es_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;
   logic                 out_free;
   logic                 issue;
   kind_type             pick;
   logic [NUM_KINDS-1:0] rest;
   rsp_type              rsp_in;

   always_comb begin
      pick = KIND_SOURCE;
      for (int i = NUM_KINDS - 1; i >= 0; i--) begin
         if (es_ff.mask[i]) begin
            pick = kind_type'(KIND_BITS'(i));
         end
      end
      rest      = es_ff.mask & ~(NUM_KINDS'(1) << pick);
      out_free  = !rsp_valid_ff || rsp_ready;
      issue     = (es_ff.mask != '0) && out_free;
      set_ready = (es_ff.mask == '0) || (issue && rest == '0);

      rsp_in.edge_kind  = pick;
      rsp_in.from_node  = (pick == KIND_SOURCE) ? es_ff.src : es_ff.me;
      rsp_in.to_node    = es_ff.to[pick];
      rsp_in.capacity   = es_ff.cap[pick];
      rsp_in.edge_value = (pick == KIND_SOURCE || pick == KIND_SINK) ? es_ff.m : es_ff.c;
      rsp_in.last       = (rest == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         es_ff.mask   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (set_valid && set_ready) begin
            es_ff <= set_data;
         end else if (issue) begin
            es_ff.mask <= rest;
         end
         if (issue) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/core/grid_graph_cut_edge_builder.sv
// Streams a greyscale image in raster order and emits the 4-connected min-cut edge list,
// one edge per cycle while rsp_ready holds: for each pixel its source and sink edges, then
// left, right, below and above edges, with the edges of a row emitted as the next row
// arrives and one drain request per column flushing the last row. The single output
// register sends one edge per cycle while rsp_ready holds; the next request is taken
// while the edges of the previous one are still going out, and the first edge of a
// request goes through the stage register, the edge-set register and the output
// register. Two 1024x16 row buffers, each read at two columns per request with a
// registered read, hold the last two rows; a write is forwarded to a read of the
// following request. The buffers need no clearing pass after reset.
module grid_graph_cut_edge_builder
   import gcb_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  req_type                 req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rsp_type                 rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]     csr_data
);

   logic [DIM_BITS-1:0]  width_raw_ff;
   logic [DIM_BITS-1:0]  height_raw_ff;
   logic [GRAY_BITS-1:0] max_gray_ff;
   cfg_type              cfg;

   logic [COL_BITS-1:0]  column_count_ff;
   logic [COL_BITS-1:0]  column_count_in;
   logic [DIM_BITS-1:0]  row_count_ff;
   logic [DIM_BITS-1:0]  row_count_in;

   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   stage_type            s1_ff;
   stage_type            s1_in;
   logic                 s1_fire;
   logic                 set_ready;

   logic                 accept;
   logic                 draining;
   logic                 act_pixel;
   logic                 act_drain;
   logic [DIM_BITS-1:0]  col_ext;
   logic [DIM_BITS-1:0]  x_ext;
   logic [DIM_BITS-1:0]  x_next;
   logic                 wrap;
   logic [DIM_BITS-1:0]  y;
   logic [PROD_BITS-1:0] rowbase_prod;
   logic [PROD_BITS-1:0] src_prod;

   mem_rd_type           rd_data;
   edge_set_type         edge_set;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_raw_ff  <= DIM_BITS'(1);
         height_raw_ff <= DIM_BITS'(1);
         max_gray_ff   <= GRAY_BITS'(255);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: begin
               width_raw_ff <= csr_data[DIM_BITS-1:0];
            end
            CSR_IMAGE_HEIGHT: begin
               height_raw_ff <= csr_data[DIM_BITS-1:0];
            end
            CSR_MAX_GRAY: begin
               max_gray_ff <= csr_data[GRAY_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cfg.width    = (width_raw_ff == '0) ? DIM_BITS'(1) :
                     (width_raw_ff > DIM_BITS'(MAX_WIDTH)) ? DIM_BITS'(MAX_WIDTH) : width_raw_ff;
      cfg.height   = (height_raw_ff == '0) ? DIM_BITS'(1) :
                     (height_raw_ff > DIM_BITS'(MAX_HEIGHT)) ? DIM_BITS'(MAX_HEIGHT)
                                                             : height_raw_ff;
      cfg.max_gray = max_gray_ff;
   end

   assign s1_fire   = s1_valid_ff && set_ready;
   assign req_ready = !s1_valid_ff || s1_fire;
   assign accept    = req_valid && req_ready;

   always_comb begin
      draining  = row_count_ff >= cfg.height;
      act_pixel = !req_data.mode && !draining;
      act_drain = req_data.mode && draining;
      col_ext   = DIM_BITS'(column_count_ff);
      x_ext     = (col_ext < cfg.width) ? col_ext : (cfg.width - DIM_BITS'(1));
      x_next    = x_ext + DIM_BITS'(1);
      wrap      = x_next >= cfg.width;
      y         = act_drain ? (cfg.height - DIM_BITS'(1)) : (row_count_ff - DIM_BITS'(1));

      rowbase_prod = PROD_BITS'(y) * PROD_BITS'(cfg.width);
      src_prod     = PROD_BITS'(cfg.width) * PROD_BITS'(cfg.height);

      s1_in.x         = x_ext[COL_BITS-1:0];
      s1_in.v         = sat(GRAY_BITS'(req_data.pixel_value[PIXEL_BITS-1:0]), cfg.max_gray);
      s1_in.emit      = act_drain || (act_pixel && row_count_ff != '0);
      s1_in.wprev     = act_pixel;
      s1_in.has_below = act_pixel;
      s1_in.y_pos     = y != '0;
      s1_in.rowbase   = rowbase_prod[NODE_BITS-1:0];
      s1_in.src       = src_prod[NODE_BITS-1:0];

      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (accept && (act_pixel || act_drain)) begin
         if (wrap) begin
            column_count_in = '0;
            row_count_in    = act_pixel ? (row_count_ff + DIM_BITS'(1)) : '0;
         end else begin
            column_count_in = x_next[COL_BITS-1:0];
         end
      end

      s1_valid_in = accept || (s1_valid_ff && !s1_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= '0;
         s1_valid_ff     <= 1'b0;
      end else begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         s1_valid_ff     <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   gcb_row_mem u_row_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_x    (s1_in.x),
      .wr_prev (s1_fire && s1_ff.wprev),
      .wr_rbp  (s1_fire && s1_ff.emit),
      .wr_data (s1_ff.v),
      .rd_data (rd_data)
   );

   gcb_edge_calc u_edge_calc (
      .stage    (s1_ff),
      .rd_data  (rd_data),
      .cfg      (cfg),
      .edge_set (edge_set)
   );

   gcb_edge_seq u_edge_seq (
      .clock     (clock),
      .reset     (reset),
      .set_valid (s1_valid_ff),
      .set_data  (edge_set),
      .set_ready (set_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assert property (@(posedge clock) disable iff (reset)
      row_count_ff <= DIM_BITS'(MAX_HEIGHT))
      else $error("row count beyond image height limit");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last
      |=> rsp_valid && (rsp_data.edge_kind > $past(rsp_data.edge_kind)))
      else $error("edges of one request not sent back to back in kind order");

   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_fire |=> s1_valid_ff && $stable(s1_ff))
      else $error("stalled request lost its stage state");

endmodule
